// File: sv/scfl_pkg.sv
package scfl_pkg;

	// Region and class table sizing
	localparam int SLOTS    = 4096;
	localparam int CLASSES  = 16;

	// Fixed field widths
	localparam int HANDLE_W = 12;
	localparam int SIZE_W   = 16;
	localparam int INIT_W   = 11;
	localparam int STATUS_W = 2;

	// Derived widths
	localparam int PTR_W    = $clog2(SLOTS + 1);
	localparam int ADDR_W   = $clog2(SLOTS);
	localparam int NEED_W   = PTR_W + 1;
	localparam int CLS_W    = (CLASSES > 1) ? $clog2(CLASSES) : 1;
	localparam int COUNT_W  = $clog2(CLASSES + 1);

	localparam logic [INIT_W-1:0] INIT_RESET = INIT_W'(32);
	localparam logic [PTR_W-1:0]  EMPTY_MARK = PTR_W'(SLOTS);

	// Commands
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_TABLE_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EXHAUSTED    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FREE_IGNORED = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_RESOLVE,
		S_ALLOC,
		S_LINK,
		S_GROW,
		S_DONE
	} fsm_state_t;

	// Answer of the shared region carve unit
	typedef struct packed {
		logic             fits;
		logic [PTR_W-1:0] new_end;
	} carve_res_t;

endpackage

// File: sv/size_class_free_list_allocator.sv
// Size-class slot allocator. Pulse start with command, req_size and
// slot_handle_in while busy is low; the request is taken on that edge and busy
// stays high until the answer is out. The answer (slot_handle, status) is shown
// for exactly one cycle with done high and cannot be held off, so capture it on
// that edge. Per request, the class lookup walks the registered size tags one
// per cycle through a single comparator, then a short sequence pops the free
// stack (one read of the link memory), carves from the class range or grows the
// class through one shared region carve unit. Write initial_slots through
// cfg_write/cfg_data only while busy is low; a value of zero carves one slot. No
// clearing pass is needed after reset.
module size_class_free_list_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           command,
	input  logic [scfl_pkg::SIZE_W-1:0]    req_size,
	input  logic [scfl_pkg::HANDLE_W-1:0]  slot_handle_in,
	output logic                           done,
	output logic [scfl_pkg::HANDLE_W-1:0]  slot_handle,
	output logic [scfl_pkg::STATUS_W-1:0]  status,
	input  logic                           cfg_write,
	input  logic [scfl_pkg::INIT_W-1:0]    cfg_data
);
	import scfl_pkg::*;

	fsm_state_t state_q, state_d;

	// Request and result registers
	logic                cmd_q;
	logic [SIZE_W-1:0]   size_q;
	logic [HANDLE_W-1:0] hin_q;
	logic                found_q;
	logic [CLS_W-1:0]    cls_q;
	logic [COUNT_W-1:0]  idx_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [STATUS_W-1:0] status_q;

	// Allocator state
	logic [INIT_W-1:0]   init_q;
	logic [COUNT_W-1:0]  class_count_q;
	logic [PTR_W-1:0]    bump_q;
	logic [SIZE_W-1:0]   class_size_q [CLASSES];
	logic [PTR_W-1:0]    head_q       [CLASSES];
	logic [PTR_W-1:0]    cursor_q     [CLASSES];
	logic [PTR_W-1:0]    end_q        [CLASSES];
	logic [PTR_W-1:0]    elem_q       [CLASSES];

	// Working values
	logic                scan_end, scan_hit;
	logic                table_full, hin_ok;
	logic [NEED_W-1:0]   init_n, grow_need, carve_need;
	logic [PTR_W-1:0]    head_c, cursor_c, end_c, elem_c;
	logic                head_valid, carve_avail, grow_now;
	logic [PTR_W+1:0]    cnt3;
	logic [PTR_W-1:0]    cnt_next;
	carve_res_t          carve_res;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
	logic [PTR_W-1:0]    ram_rdata;

	// Serial tag compare
	assign scan_end = (idx_q == class_count_q);
	assign scan_hit = !scan_end && (class_size_q[idx_q[CLS_W-1:0]] == size_q);

	assign table_full = (class_count_q >= COUNT_W'(CLASSES));
	assign hin_ok     = (PTR_W'(hin_q) < PTR_W'(SLOTS));

	// Current class fields
	assign head_c      = head_q[cls_q];
	assign cursor_c    = cursor_q[cls_q];
	assign end_c       = end_q[cls_q];
	assign elem_c      = elem_q[cls_q];
	assign head_valid  = (head_c < PTR_W'(SLOTS));
	assign carve_avail = (cursor_c < end_c);
	assign grow_now    = !head_valid && !carve_avail;

	// Operand select for the shared carve unit
	assign init_n     = (init_q == '0) ? NEED_W'(1) : NEED_W'(init_q);
	assign grow_need  = {elem_c, 1'b0};
	assign carve_need = (state_q == S_RESOLVE) ? init_n : grow_need;

	scfl_carve u_carve (
		.bump (bump_q),
		.need (carve_need),
		.res  (carve_res)
	);

	// Triple the running count, saturate at the region size
	assign cnt3     = {elem_c, 1'b0} + (PTR_W+2)'(elem_c);
	assign cnt_next = (cnt3 > (PTR_W+2)'(SLOTS)) ? PTR_W'(SLOTS) : cnt3[PTR_W-1:0];

	// Link memory: push on free, read on pop
	assign ram_waddr = ADDR_W'(hin_q);
	assign ram_raddr = head_c[ADDR_W-1:0];

	scfl_ram #(
		.WIDTH (PTR_W),
		.DEPTH (SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (head_c),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (scan_hit || scan_end) state_d = S_RESOLVE;
			end
			S_RESOLVE: begin
				if (cmd_q == CMD_FREE) state_d = S_DONE;
				else if (found_q) state_d = S_ALLOC;
				else if (table_full || !carve_res.fits) state_d = S_DONE;
				else state_d = S_ALLOC;
			end
			S_ALLOC: begin
				if (head_valid) state_d = S_LINK;
				else if (carve_avail) state_d = S_GROW;
				else state_d = S_DONE;
			end
			S_LINK:  state_d = S_GROW;
			S_GROW:  state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		busy   = (state_q != S_IDLE);
		done   = (state_q == S_DONE);
		ram_we = (state_q == S_RESOLVE) && (cmd_q == CMD_FREE) && found_q && hin_ok;
	end

	assign slot_handle = handle_q;
	assign status      = status_q;

	// Control state, counts and stack heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			init_q        <= INIT_RESET;
			class_count_q <= '0;
			bump_q        <= '0;
			found_q       <= 1'b0;
			idx_q         <= '0;
			for (int i = 0; i < CLASSES; i++) begin
				head_q[i] <= EMPTY_MARK;
			end
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				init_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					idx_q   <= '0;
					found_q <= 1'b0;
				end
				S_SCAN: begin
					if (scan_hit) found_q <= 1'b1;
					else if (!scan_end) idx_q <= idx_q + COUNT_W'(1);
				end
				S_RESOLVE: begin
					if (cmd_q == CMD_FREE) begin
						if (ram_we) head_q[cls_q] <= PTR_W'(hin_q);
					end else if (!found_q && !table_full && carve_res.fits) begin
						head_q[class_count_q[CLS_W-1:0]] <= EMPTY_MARK;
						class_count_q <= class_count_q + COUNT_W'(1);
						bump_q        <= carve_res.new_end;
					end
				end
				S_LINK: begin
					head_q[cls_q] <= ram_rdata;
				end
				S_GROW: begin
					if (grow_now && carve_res.fits) bump_q <= carve_res.new_end;
				end
				default: begin
				end
			endcase
		end
	end

	// Request capture, result and per-class payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q    <= command;
				size_q   <= req_size;
				hin_q    <= slot_handle_in;
				handle_q <= '0;
				status_q <= STAT_OK;
			end
			S_SCAN: begin
				if (scan_hit) cls_q <= idx_q[CLS_W-1:0];
			end
			S_RESOLVE: begin
				if (cmd_q == CMD_FREE) begin
					if (!ram_we) status_q <= STAT_FREE_IGNORED;
				end else if (!found_q) begin
					if (table_full) begin
						status_q <= STAT_TABLE_FULL;
					end else if (!carve_res.fits) begin
						status_q <= STAT_EXHAUSTED;
					end else begin
						cls_q <= class_count_q[CLS_W-1:0];
						class_size_q[class_count_q[CLS_W-1:0]] <= size_q;
						cursor_q[class_count_q[CLS_W-1:0]]     <= bump_q;
						end_q[class_count_q[CLS_W-1:0]]        <= carve_res.new_end;
						elem_q[class_count_q[CLS_W-1:0]]       <= init_n[PTR_W-1:0];
					end
				end
			end
			S_ALLOC: begin
				if (head_valid) begin
					handle_q <= HANDLE_W'(head_c);
				end else if (carve_avail) begin
					handle_q        <= HANDLE_W'(cursor_c);
					cursor_q[cls_q] <= cursor_c + PTR_W'(1);
				end else begin
					status_q <= STAT_EXHAUSTED;
				end
			end
			S_GROW: begin
				if (grow_now && carve_res.fits) begin
					cursor_q[cls_q] <= bump_q;
					end_q[cls_q]    <= carve_res.new_end;
					elem_q[cls_q]   <= cnt_next;
				end
			end
			default: begin
			end
		endcase
	end

	// Checks
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted request did not raise busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		class_count_q <= COUNT_W'(CLASSES)) else $error("class count beyond table");

	a_bump_range: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= PTR_W'(SLOTS)) else $error("region cursor beyond region");

	a_ignore_free: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_FREE_IGNORED |-> cmd_q == CMD_FREE)
		else $error("ignored-free status on an allocate");

	a_full_table: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_TABLE_FULL |-> class_count_q == COUNT_W'(CLASSES))
		else $error("table-full status with free class entries");

endmodule

// File: sv/scfl_ram.sv
module scfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/scfl_carve.sv
module scfl_carve (
	input  logic [scfl_pkg::PTR_W-1:0]  bump,
	input  logic [scfl_pkg::NEED_W-1:0] need,
	output scfl_pkg::carve_res_t        res
);
	import scfl_pkg::*;

	logic [NEED_W-1:0] room;
	logic [NEED_W-1:0] sum;

	// Compare the request against what is left of the region
	assign room        = NEED_W'(SLOTS) - NEED_W'(bump);
	assign sum         = NEED_W'(bump) + need;
	assign res.fits    = (need <= room);
	assign res.new_end = sum[PTR_W-1:0];

endmodule

// File: dv/size_class_free_list_allocator_tb.sv
`timescale 1ns / 1ps

module size_class_free_list_allocator_tb;
	import scfl_pkg::*;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [STATUS_W-1:0] stat;
	} grant_t;

	typedef struct packed {
		logic [SIZE_W-1:0]   tag;
		logic [HANDLE_W-1:0] slot;
	} held_slot_t;

	// Slot pool ledger: tracks class tables, free stacks and the shared region,
	// and keeps the answers still owed by the block in request order.
	class slot_pool_scoreboard;
		bit [INIT_W-1:0] init_slots;
		bit [SIZE_W-1:0] class_tag[CLASSES];
		int unsigned     n_classes;
		bit [PTR_W-1:0]  stack_top[CLASSES];
		bit [PTR_W-1:0]  cursor[CLASSES];
		bit [PTR_W-1:0]  range_end[CLASSES];
		bit [PTR_W-1:0]  elem_count[CLASSES];
		bit [PTR_W-1:0]  link[SLOTS];
		int unsigned     bump;
		grant_t          pending_grants[$];
		int unsigned     mismatches;
		int unsigned     status_seen[4];

		function new();
			init_slots = INIT_RESET;
			n_classes = 0;
			bump = 0;
			mismatches = 0;
			foreach (stack_top[i]) stack_top[i] = EMPTY_MARK;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function int find_tag(bit [SIZE_W-1:0] size);
			for (int i = 0; i < n_classes; i++)
				if (class_tag[i] == size) return i;
			return -1;
		endfunction

		function int unsigned region_left();
			return SLOTS - bump;
		endfunction

		// Take n slots from the top of the shared region for class c
		function bit carve_range(int c, int unsigned n);
			if (n > SLOTS - bump) return 0;
			cursor[c] = PTR_W'(bump);
			range_end[c] = PTR_W'(bump + n);
			bump += n;
			return 1;
		endfunction

		function grant_t note_request(logic cmd, logic [SIZE_W-1:0] size,
				logic [HANDLE_W-1:0] hin);
			grant_t g;
			int cls;
			int unsigned n, cnt, top;
			bit ok;
			g.handle = '0;
			g.stat = STAT_OK;
			cls = find_tag(size);
			if (cmd == CMD_FREE) begin
				// push onto the class stack, no ownership check
				if (cls < 0 || int'(hin) >= SLOTS) begin
					g.stat = STAT_FREE_IGNORED;
				end else begin
					link[hin] = stack_top[cls];
					stack_top[cls] = PTR_W'(hin);
				end
			end else begin
				ok = 1;
				// register a new size class
				if (cls < 0) begin
					n = (init_slots == 0) ? 1 : init_slots;
					if (n_classes >= CLASSES) begin
						g.stat = STAT_TABLE_FULL;
						ok = 0;
					end else if (!carve_range(n_classes, n)) begin
						g.stat = STAT_EXHAUSTED;
						ok = 0;
					end else begin
						cls = n_classes;
						class_tag[cls] = size;
						stack_top[cls] = EMPTY_MARK;
						elem_count[cls] = PTR_W'(n);
						n_classes++;
					end
				end
				// pop the stack first, then carve sequentially
				if (ok) begin
					top = stack_top[cls];
					if (top < SLOTS) begin
						g.handle = HANDLE_W'(top);
						stack_top[cls] = link[top];
					end else if (cursor[cls] < range_end[cls]) begin
						g.handle = HANDLE_W'(cursor[cls]);
						cursor[cls]++;
					end else begin
						g.stat = STAT_EXHAUSTED;
						ok = 0;
					end
				end
				// grow a class that this grant left with nothing in hand
				if (ok && stack_top[cls] >= SLOTS && cursor[cls] >= range_end[cls]) begin
					cnt = elem_count[cls];
					if (carve_range(cls, 2 * cnt)) begin
						cnt = 3 * cnt;
						if (cnt > SLOTS) cnt = SLOTS;
						elem_count[cls] = PTR_W'(cnt);
					end
				end
			end
			pending_grants.push_back(g);
			return g;
		endfunction

		function void check_grant(logic [HANDLE_W-1:0] h, logic [STATUS_W-1:0] st);
			grant_t want;
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR %0t: result with no request outstanding: handle %0d status %0d",
						$time, h, st);
				return;
			end
			want = pending_grants.pop_front();
			status_seen[want.stat]++;
			if (h !== want.handle || st !== want.stat) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR %0t: expected handle %0d status %0d, got handle %0d status %0d",
						$time, want.handle, want.stat, h, st);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                command;
	logic [SIZE_W-1:0]   req_size;
	logic [HANDLE_W-1:0] slot_handle_in;
	logic                done;
	logic [HANDLE_W-1:0] slot_handle;
	logic [STATUS_W-1:0] status;
	logic                cfg_write;
	logic [INIT_W-1:0]   cfg_data;

	slot_pool_scoreboard ledger;
	held_slot_t          held[$];
	logic [SIZE_W-1:0]   size_pool[$];
	bit                  idle_on;
	int unsigned         n_requests;
	int unsigned         n_settings;

	size_class_free_list_allocator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.req_size       (req_size),
		.slot_handle_in (slot_handle_in),
		.done           (done),
		.slot_handle    (slot_handle),
		.status         (status),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Check every answer on the edge that ends its strobe cycle
	always @(posedge clk) begin
		if (arst_n && done)
			ledger.check_grant(slot_handle, status);
	end

	initial begin
		#5_000_000;
		$display("size_class_free_list_allocator regression: fail");
		$finish;
	end

	function automatic logic [SIZE_W-1:0] fresh_size();
		logic [SIZE_W-1:0] s;
		do s = SIZE_W'($urandom_range(1, 65535)); while (ledger.find_tag(s) >= 0);
		return s;
	endfunction

	// Present one request at a falling edge and hold it until the block takes it
	task automatic issue(input logic cmd, input logic [SIZE_W-1:0] size,
			input logic [HANDLE_W-1:0] hin, output grant_t g);
		while (idle_on && $urandom_range(0, 99) < 23) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		command = cmd;
		req_size = size;
		slot_handle_in = hin;
		do @(posedge clk); while (busy);
		g = ledger.note_request(cmd, size, hin);
		n_requests++;
		if (cmd == CMD_ALLOC && g.stat == STAT_OK)
			held.push_back('{tag: size, slot: g.handle});
		@(negedge clk);
	endtask

	// Drop start and wait until every answer is back and the block is idle
	task automatic settle();
		start = 1'b0;
		while (ledger.pending_grants.size() != 0 || busy) @(negedge clk);
	endtask

	task automatic write_initial_slots(input logic [INIT_W-1:0] v);
		settle();
		cfg_write = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_write = 1'b0;
		ledger.init_slots = v;
		n_settings++;
	endtask

	// Mostly allocations and frees of held slots, with stray and unknown-size frees and, if fresh_ok, new-size allocations
	task automatic random_phase(input int unsigned items, input bit fresh_ok);
		grant_t      g;
		held_slot_t  hs;
		int unsigned pick, idx;
		repeat (items) begin
			pick = $urandom_range(0, 99);
			if (pick < 35 && held.size() != 0) begin
				idx = $urandom_range(0, held.size() - 1);
				hs = held[idx];
				held.delete(idx);
				issue(CMD_FREE, hs.tag, hs.slot, g);
			end else if (pick >= 35 && pick < 40) begin
				idx = $urandom_range(0, size_pool.size() - 1);
				issue(CMD_FREE, size_pool[idx], HANDLE_W'($urandom_range(0, 4095)), g);
			end else if (pick >= 40 && pick < 45) begin
				issue(CMD_FREE, fresh_size(), HANDLE_W'($urandom_range(0, 4095)), g);
			end else if (pick >= 45 && pick < 48 && fresh_ok) begin
				issue(CMD_ALLOC, fresh_size(), HANDLE_W'($urandom_range(0, 4095)), g);
			end else begin
				idx = $urandom_range(0, size_pool.size() - 1);
				issue(CMD_ALLOC, size_pool[idx], HANDLE_W'($urandom_range(0, 4095)), g);
			end
		end
	endtask

	initial begin
		grant_t            g;
		logic [SIZE_W-1:0] s, last_tag;
		int unsigned       room, k;
		ledger = new();
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_ALLOC;
		req_size = '0;
		slot_handle_in = '0;
		cfg_write = 1'b0;
		cfg_data = '0;
		idle_on = 1'b1;
		n_requests = 0;
		n_settings = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zero setting acts as one, growth, stack reuse, foreign and double frees
		write_initial_slots('0);
		issue(CMD_ALLOC, 16'd1, 12'hFFF, g);
		issue(CMD_ALLOC, 16'd1, 12'd0, g);
		issue(CMD_ALLOC, 16'd1, 12'hFFF, g);
		issue(CMD_FREE, 16'd1, 12'd2, g);
		issue(CMD_FREE, 16'd1, 12'd0, g);
		issue(CMD_ALLOC, 16'd1, 12'd0, g);
		issue(CMD_ALLOC, 16'd1, 12'd0, g);
		issue(CMD_FREE, 16'hFFFF, 12'd7, g);
		issue(CMD_FREE, 16'd1, 12'hFFF, g);
		issue(CMD_ALLOC, 16'd1, 12'd0, g);
		issue(CMD_FREE, 16'd1, 12'd3, g);
		issue(CMD_FREE, 16'd1, 12'd3, g);
		issue(CMD_ALLOC, 16'd1, 12'd0, g);
		issue(CMD_ALLOC, 16'd1, 12'd0, g);
		issue(CMD_ALLOC, 16'hFFFF, 12'hFFF, g);
		issue(CMD_FREE, 16'hFFFF, 12'hFFF, g);
		issue(CMD_ALLOC, 16'hFFFF, 12'd0, g);

		// Random traffic over a small set of sizes while the region still has room
		size_pool = '{16'd1, 16'hFFFF};
		repeat (6) size_pool.push_back(fresh_size());
		write_initial_slots(INIT_W'($urandom_range(2, 6)));
		random_phase(150, 1'b0);
		write_initial_slots(INIT_W'($urandom_range(1, 8)));
		random_phase(150, 1'b0);

		// Register big classes until the region cannot hold another or the table is full
		write_initial_slots(11'd1024);
		do issue(CMD_ALLOC, fresh_size(), '0, g);
		while (g.stat == STAT_OK && ledger.n_classes < CLASSES);

		// Leave exactly three slots per free table entry, then fill the table
		room = ledger.region_left();
		k = CLASSES - ledger.n_classes;
		if (k != 0 && room > 3 * k && room - 3 * k < 2048) begin
			write_initial_slots(INIT_W'(room - 3 * k));
			issue(CMD_ALLOC, fresh_size(), '1, g);
		end
		write_initial_slots(11'd1);
		last_tag = 16'd1;
		do begin
			s = fresh_size();
			issue(CMD_ALLOC, s, '0, g);
			if (g.stat == STAT_OK) last_tag = s;
		end while (g.stat == STAT_OK);

		// Drain the newest class past a failed growth
		repeat (3) issue(CMD_ALLOC, last_tag, '0, g);

		// Random traffic over every registered size with the region used up
		size_pool.delete();
		for (int i = 0; i < ledger.n_classes; i++) size_pool.push_back(ledger.class_tag[i]);
		write_initial_slots(INIT_W'($urandom_range(1, 1024)));
		idle_on = 1'b0;
		random_phase(120, 1'b1);
		idle_on = 1'b1;
		random_phase(200, 1'b1);

		settle();
		repeat (30) @(negedge clk);
		$display("Ran %0d requests over %0d initial_slots settings; %0d classes hold %0d of %0d slots.",
			n_requests, n_settings, ledger.n_classes, SLOTS - ledger.region_left(), SLOTS);
		$display("Answers: %0d granted, %0d table full, %0d exhausted, %0d frees ignored.",
			ledger.status_seen[STAT_OK], ledger.status_seen[STAT_TABLE_FULL],
			ledger.status_seen[STAT_EXHAUSTED], ledger.status_seen[STAT_FREE_IGNORED]);
		if (ledger.mismatches == 0 && ledger.pending_grants.size() == 0) begin
			$display("size_class_free_list_allocator regression: pass");
		end else begin
			$display("%0d mismatches, %0d answers missing", ledger.mismatches,
				ledger.pending_grants.size());
			$display("size_class_free_list_allocator regression: fail");
		end
		$finish;
	end

endmodule

// File: size_class_free_list_allocator.f
sv/scfl_pkg.sv
sv/scfl_ram.sv
sv/scfl_carve.sv
sv/size_class_free_list_allocator.sv
dv/size_class_free_list_allocator_tb.sv
